>>> rtl/clipped_alpha_sprite_blitter_core_defines.svh
// ----------------------------------------------------------------------------
// blitter assertion macros
// shared property wrappers for the port-level checker
// ----------------------------------------------------------------------------
`ifndef CLIPPED_ALPHA_SPRITE_BLITTER_CORE_DEFINES_SVH
`define CLIPPED_ALPHA_SPRITE_BLITTER_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define CAB_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("blitter check failed");

// next-cycle implication, off during reset
`define CAB_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("blitter check failed");

// next-cycle implication that also covers reset itself
`define CAB_ASSERT_RESET(label, pre, post) \
  label: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("blitter reset check failed");

`endif

>>> rtl/cab_pkg.sv
// ----------------------------------------------------------------------------
// cab_pkg
// types and constants shared by the sprite blitter modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cab_pkg;

  localparam int CANVAS_ADDR_W = 16;
  localparam int CANVAS_DEPTH  = 65536;
  localparam int RGBA_W        = 32;
  localparam int DIM_W         = 9;
  localparam int ORIGIN_W      = 11;
  localparam int KIND_W        = 2;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 11;
  localparam int SUM_W         = 16;

  localparam int CMD_DEPTH     = 4;
  localparam int RES_DEPTH     = 4;
  localparam int RES_CNT_W     = $clog2(RES_DEPTH + 1);

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  // input kinds
  localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y      = 3'd5;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_CLIP  = 3'd1,
    OP_STORE = 3'd2,
    OP_BLEND = 3'd3,
    OP_READ  = 3'd4
  } op_t;

  typedef struct packed {
    op_t                      op;
    logic [CANVAS_ADDR_W-1:0] addr;
    logic [RGBA_W-1:0]        data;
  } cmd_t;

  typedef struct packed {
    logic [CANVAS_ADDR_W-1:0] addr;
    logic [RGBA_W-1:0]        rgba;
    logic                     written;
    logic                     clipped;
  } res_t;

  // exact floor(x / 255) for x up to 65279, which covers every blend sum
  function automatic logic [7:0] div255(input logic [SUM_W-1:0] x);
    logic [SUM_W:0] t;
    t = {1'b0, x} + {9'd0, x[SUM_W-1:8]} + 17'd1;
    return t[15:8];
  endfunction

endpackage

>>> rtl/cab_ram.sv
// ----------------------------------------------------------------------------
// cab_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cab_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    // read returns the old word on a same-address write
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/cab_fifo.sv
// ----------------------------------------------------------------------------
// cab_fifo
// small register queue with occupancy count
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cab_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           pop_data,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign count   = count_r;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/cab_front.sv
// ----------------------------------------------------------------------------
// cab_front
// config registers, raster counters, clipping and canvas address
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cab_front #(
  parameter int MAX_CANVAS_DIM   = 256,
  parameter int MAX_SPRITE_DIM   = 256,
  parameter int OPAQUE_THRESHOLD = 250
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [cab_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cab_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_push,
  input  logic [cab_pkg::KIND_W-1:0]        in_kind,
  input  logic                              in_sprite_start,
  input  logic [cab_pkg::RGBA_W-1:0]        in_data_rgba,
  input  logic [cab_pkg::CANVAS_ADDR_W-1:0] in_canvas_address,
  input  logic                              cmd_full,
  output logic                              cmd_push,
  output cab_pkg::cmd_t                     cmd
);

  localparam int DW = cab_pkg::DIM_W;
  localparam int OW = cab_pkg::ORIGIN_W;

  logic [DW-1:0] cw_r, ch_r, sw_r, sh_r;
  logic [OW-1:0] ox_r, oy_r;
  logic [DW-1:0] col_r, col_nxt;
  logic [DW-1:0] row_r, row_nxt;

  logic [DW-1:0]     cw, ch, sw, sh;
  logic [DW-1:0]     col_base, row_base;
  logic [DW:0]       col_inc, row_inc;
  logic signed [OW:0] dx, dy;
  logic              clip;
  logic [2*DW-1:0]   addr_full;
  logic [7:0]        alpha;
  logic              accept;

  function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v,
                                              input logic [OW-1:0] maxv);
    logic [DW-1:0] r;
    if (v == '0) begin
      r = DW'(1);
    end else if ({2'b00, v} > maxv) begin
      r = maxv[DW-1:0];
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign cw = clamp_dim(cw_r, OW'(MAX_CANVAS_DIM));
  assign ch = clamp_dim(ch_r, OW'(MAX_CANVAS_DIM));
  assign sw = clamp_dim(sw_r, OW'(MAX_SPRITE_DIM));
  assign sh = clamp_dim(sh_r, OW'(MAX_SPRITE_DIM));

  assign accept   = in_push && !cmd_full;
  assign cmd_push = accept;
  assign alpha    = in_data_rgba[31:24];

  assign col_base = in_sprite_start ? '0 : col_r;
  assign row_base = in_sprite_start ? '0 : row_r;

  assign dx = $signed({ox_r[OW-1], ox_r}) + $signed({3'b000, col_base});
  assign dy = $signed({oy_r[OW-1], oy_r}) + $signed({3'b000, row_base});

  assign clip = dx[OW] || dy[OW] ||
                (dx[OW-1:0] >= {2'b00, cw}) || (dy[OW-1:0] >= {2'b00, ch});

  // only meaningful on canvas, where both offsets fit the dimension width
  assign addr_full = (2*DW)'(dy[DW-1:0]) * (2*DW)'(cw) + (2*DW)'(dx[DW-1:0]);

  // raster advance
  always_comb begin
    col_inc = {1'b0, col_base} + 1'b1;
    row_inc = {1'b0, row_base} + 1'b1;
    if (col_inc >= {1'b0, sw}) begin
      col_nxt = '0;
      row_nxt = (row_inc >= {1'b0, sh}) ? '0 : row_inc[DW-1:0];
    end else begin
      col_nxt = col_inc[DW-1:0];
      row_nxt = row_base;
    end
  end

  always_comb begin
    cmd.op   = cab_pkg::OP_NONE;
    cmd.addr = '0;
    cmd.data = '0;
    case (in_kind)
      cab_pkg::KIND_PIXEL: begin
        if (clip) begin
          cmd.op = cab_pkg::OP_CLIP;
        end else if (alpha != 8'd0) begin
          cmd.addr = addr_full[cab_pkg::CANVAS_ADDR_W-1:0];
          if (alpha >= 8'(OPAQUE_THRESHOLD)) begin
            cmd.op   = cab_pkg::OP_STORE;
            cmd.data = {cab_pkg::ALPHA_OPAQUE, in_data_rgba[23:0]};
          end else begin
            cmd.op   = cab_pkg::OP_BLEND;
            cmd.data = in_data_rgba;
          end
        end
      end
      cab_pkg::KIND_READ: begin
        cmd.op   = cab_pkg::OP_READ;
        cmd.addr = in_canvas_address;
      end
      cab_pkg::KIND_WRITE: begin
        cmd.op   = cab_pkg::OP_STORE;
        cmd.addr = in_canvas_address;
        cmd.data = in_data_rgba;
      end
      default: begin
        cmd.op = cab_pkg::OP_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_r  <= DW'(256);
      ch_r  <= DW'(256);
      sw_r  <= DW'(1);
      sh_r  <= DW'(1);
      ox_r  <= '0;
      oy_r  <= '0;
      col_r <= '0;
      row_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          cab_pkg::CFG_CANVAS_WIDTH:  cw_r <= cfg_data[DW-1:0];
          cab_pkg::CFG_CANVAS_HEIGHT: ch_r <= cfg_data[DW-1:0];
          cab_pkg::CFG_SPRITE_WIDTH:  sw_r <= cfg_data[DW-1:0];
          cab_pkg::CFG_SPRITE_HEIGHT: sh_r <= cfg_data[DW-1:0];
          cab_pkg::CFG_ORIGIN_X:      ox_r <= cfg_data;
          cab_pkg::CFG_ORIGIN_Y:      oy_r <= cfg_data;
          default: begin
          end
        endcase
      end
      if (accept && (in_kind == cab_pkg::KIND_PIXEL)) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

endmodule

>>> rtl/cab_back.sv
// ----------------------------------------------------------------------------
// cab_back
// canvas read, forwarded blend and write-back, one request per cycle while a result slot is free
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cab_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cmd_empty,
  input  cab_pkg::cmd_t                 cmd,
  output logic                          cmd_pop,
  input  logic [cab_pkg::RES_CNT_W-1:0] res_count,
  output logic                          res_push,
  output cab_pkg::res_t                 res
);

  localparam int AW = cab_pkg::CANVAS_ADDR_W;
  localparam int RW = cab_pkg::RGBA_W;
  localparam int SW = cab_pkg::SUM_W;
  localparam int CW = cab_pkg::RES_CNT_W;

  // stage 2: read data back, forward, multiply
  logic          s2_v_r;
  cab_pkg::cmd_t s2_cmd_r;
  // stage 3: divide, write, result
  logic          s3_v_r;
  cab_pkg::op_t  s3_op_r;
  logic [AW-1:0] s3_addr_r;
  logic [RW-1:0] s3_data_r, s3_data_nxt;
  logic [SW-1:0] s3_sum_r [3];
  logic [SW-1:0] s3_sum_nxt [3];
  // write done at the previous edge, missed by a read issued at that edge
  logic          w_v_r;
  logic [AW-1:0] w_addr_r;
  logic [RW-1:0] w_data_r;

  logic [CW:0]   in_flight;
  logic          issue;
  logic [RW-1:0] rdata, dst;
  logic          s3_we;
  logic [RW-1:0] s3_wdata;
  logic [7:0]    a, s, d;

  // keep a result slot for everything already in the pipe
  assign in_flight = {1'b0, res_count} + (CW+1)'(s2_v_r) + (CW+1)'(s3_v_r);
  assign issue     = !cmd_empty && (in_flight < (CW+1)'(cab_pkg::RES_DEPTH));
  assign cmd_pop   = issue;

  cab_ram #(
    .WIDTH (RW),
    .DEPTH (cab_pkg::CANVAS_DEPTH)
  ) u_canvas (
    .clk   (clk),
    .we    (s3_we),
    .waddr (s3_addr_r),
    .wdata (s3_wdata),
    .re    (issue),
    .raddr (cmd.addr),
    .rdata (rdata)
  );

  always_comb begin
    if (s3_we && (s3_addr_r == s2_cmd_r.addr)) begin
      dst = s3_wdata;
    end else if (w_v_r && (w_addr_r == s2_cmd_r.addr)) begin
      dst = w_data_r;
    end else begin
      dst = rdata;
    end
  end

  always_comb begin
    a = s2_cmd_r.data[31:24];
    s = '0;
    d = '0;
    for (int i = 0; i < 3; i++) begin
      s = s2_cmd_r.data[8*i +: 8];
      d = dst[8*i +: 8];
      s3_sum_nxt[i] = SW'(s) * SW'(a) + SW'(d) * SW'(8'd255 - a);
    end
    s3_data_nxt = (s2_cmd_r.op == cab_pkg::OP_READ) ? dst : s2_cmd_r.data;
  end

  assign s3_we = s3_v_r &&
                 ((s3_op_r == cab_pkg::OP_STORE) || (s3_op_r == cab_pkg::OP_BLEND));
  assign s3_wdata = (s3_op_r == cab_pkg::OP_BLEND) ?
                    {cab_pkg::ALPHA_OPAQUE, cab_pkg::div255(s3_sum_r[2]),
                     cab_pkg::div255(s3_sum_r[1]), cab_pkg::div255(s3_sum_r[0])} :
                    s3_data_r;

  assign res_push    = s3_v_r;
  assign res.addr    = s3_addr_r;
  assign res.rgba    = ((s3_op_r == cab_pkg::OP_NONE) || (s3_op_r == cab_pkg::OP_CLIP)) ?
                       '0 : s3_wdata;
  assign res.written = s3_we;
  assign res.clipped = (s3_op_r == cab_pkg::OP_CLIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      w_v_r  <= 1'b0;
    end else begin
      s2_v_r <= issue;
      s3_v_r <= s2_v_r;
      w_v_r  <= s3_we;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s2_cmd_r <= cmd;
    end
    s3_op_r   <= s2_cmd_r.op;
    s3_addr_r <= s2_cmd_r.addr;
    s3_data_r <= s3_data_nxt;
    for (int i = 0; i < 3; i++) begin
      s3_sum_r[i] <= s3_sum_nxt[i];
    end
    w_addr_r <= s3_addr_r;
    w_data_r <= s3_wdata;
  end

endmodule

>>> rtl/clipped_alpha_sprite_blitter_core.sv
// ----------------------------------------------------------------------------
// clipped alpha sprite blitter core
// an accepted request passes the request queue, the canvas read, the blend and write-back stage and the result queue
// throughput one request per cycle while result slots are free, set by the single canvas ram read port
// synchronous reset empties both queues and the pipe; canvas is not cleared
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clipped_alpha_sprite_blitter_core #(
  parameter int MAX_CANVAS_DIM   = 256,
  parameter int MAX_SPRITE_DIM   = 256,
  parameter int OPAQUE_THRESHOLD = 250
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [cab_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cab_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic [cab_pkg::KIND_W-1:0]        in_kind,
  input  logic                              in_sprite_start,
  input  logic [cab_pkg::RGBA_W-1:0]        in_data_rgba,
  input  logic [cab_pkg::CANVAS_ADDR_W-1:0] in_canvas_address,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [cab_pkg::CANVAS_ADDR_W-1:0] out_pixel_address,
  output logic [cab_pkg::RGBA_W-1:0]        out_pixel_rgba,
  output logic                              out_pixel_written,
  output logic                              out_pixel_clipped
);

  logic                          cmd_push, cmd_pop, cmd_full, cmd_empty;
  cab_pkg::cmd_t                 cmd_in, cmd_out;
  logic [$clog2(cab_pkg::CMD_DEPTH+1)-1:0] cmd_count;
  logic                          res_push, res_full;
  cab_pkg::res_t                 res_in, res_out;
  logic [cab_pkg::RES_CNT_W-1:0] res_count;

  cab_front #(
    .MAX_CANVAS_DIM   (MAX_CANVAS_DIM),
    .MAX_SPRITE_DIM   (MAX_SPRITE_DIM),
    .OPAQUE_THRESHOLD (OPAQUE_THRESHOLD)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_push           (in_push),
    .in_kind           (in_kind),
    .in_sprite_start   (in_sprite_start),
    .in_data_rgba      (in_data_rgba),
    .in_canvas_address (in_canvas_address),
    .cmd_full          (cmd_full),
    .cmd_push          (cmd_push),
    .cmd               (cmd_in)
  );

  cab_fifo #(
    .WIDTH ($bits(cab_pkg::cmd_t)),
    .DEPTH (cab_pkg::CMD_DEPTH)
  ) u_cmd_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_in),
    .pop       (cmd_pop),
    .pop_data  (cmd_out),
    .full      (cmd_full),
    .empty     (cmd_empty),
    .count     (cmd_count)
  );

  cab_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty || (cmd_count == '0)),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_count (res_count),
    .res_push  (res_push),
    .res       (res_in)
  );

  // back end reserves slots, so a push never meets a full queue
  cab_fifo #(
    .WIDTH ($bits(cab_pkg::res_t)),
    .DEPTH (cab_pkg::RES_DEPTH)
  ) u_res_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_in),
    .pop       (out_pop),
    .pop_data  (res_out),
    .full      (res_full),
    .empty     (out_empty),
    .count     (res_count)
  );

  assign in_full           = cmd_full || (res_full && 1'b0);
  assign out_pixel_address = res_out.addr;
  assign out_pixel_rgba    = res_out.rgba;
  assign out_pixel_written = res_out.written;
  assign out_pixel_clipped = res_out.clipped;

endmodule

>>> rtl/cab_checker.sv
// ----------------------------------------------------------------------------
// cab_checker
// port-level checks on the blitter, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "clipped_alpha_sprite_blitter_core_defines.svh"

module cab_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_full,
  input logic                              out_empty,
  input logic                              out_pop,
  input logic [cab_pkg::CANVAS_ADDR_W-1:0] out_pixel_address,
  input logic [cab_pkg::RGBA_W-1:0]        out_pixel_rgba,
  input logic                              out_pixel_written,
  input logic                              out_pixel_clipped
);

  // reset drops every request in flight
  `CAB_ASSERT_RESET(a_reset_empty, !rst_n, out_empty && !in_full)

  // a clipped pixel touches nothing and reports zeros
  `CAB_ASSERT_NOW(a_clip_clean, !out_empty && out_pixel_clipped,
    !out_pixel_written && (out_pixel_address == '0) && (out_pixel_rgba == '0))

  // a written word never reports clipped
  `CAB_ASSERT_NOW(a_no_write_and_clip, !out_empty && out_pixel_written,
    !out_pixel_clipped)

  // a waiting result holds until taken
  `CAB_ASSERT_NEXT(a_out_hold, !out_empty && !out_pop,
    !out_empty && $stable(out_pixel_rgba) && $stable(out_pixel_address))

endmodule

bind clipped_alpha_sprite_blitter_core cab_checker u_cab_checker (.*);

>>> verif/clipped_alpha_sprite_blitter_core_test.sv
// ----------------------------------------------------------------------------
// clipped alpha sprite blitter core test
// drives sprite pixels, canvas word writes and reads through the request
// queue, keeps its own copy of the canvas and raster counters to predict each
// result, and checks every popped result field by field in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clipped_alpha_sprite_blitter_core_test;

  import cab_pkg::*;

  localparam int MAX_CANVAS_DIM   = 256;
  localparam int MAX_SPRITE_DIM   = 256;
  localparam int OPAQUE_THRESHOLD = 250;
  localparam int DRAIN_CYCLES     = 8;

  // the fourth kind code has no function in the block
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic                     start;
    logic [RGBA_W-1:0]        rgba;
    logic [CANVAS_ADDR_W-1:0] addr;
  } blit_req_t;

  typedef enum int {RX_STEADY, RX_CHOPPY, RX_SLOW} rx_mode_t;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;
  logic                     in_push;
  logic                     in_full;
  logic [KIND_W-1:0]        in_kind;
  logic                     in_sprite_start;
  logic [RGBA_W-1:0]        in_data_rgba;
  logic [CANVAS_ADDR_W-1:0] in_canvas_address;
  logic                     out_empty;
  logic                     out_pop = 1'b0;
  logic [CANVAS_ADDR_W-1:0] out_pixel_address;
  logic [RGBA_W-1:0]        out_pixel_rgba;
  logic                     out_pixel_written;
  logic                     out_pixel_clipped;

  // predicted state of the block
  logic [RGBA_W-1:0]          canvas_img [0:CANVAS_DEPTH-1];
  bit                         canvas_known [0:CANVAS_DEPTH-1];
  int                         known_addrs[$];
  logic [DIM_W-1:0]           canvas_w_reg = 9'd256;
  logic [DIM_W-1:0]           canvas_h_reg = 9'd256;
  logic [DIM_W-1:0]           sprite_w_reg = 9'd1;
  logic [DIM_W-1:0]           sprite_h_reg = 9'd1;
  logic signed [ORIGIN_W-1:0] origin_x_reg = '0;
  logic signed [ORIGIN_W-1:0] origin_y_reg = '0;
  int                         sprite_col = 0;
  int                         sprite_row = 0;

  res_t     canvas_results_q[$];
  int       mismatches = 0;
  int       sent_count = 0;
  int       tx_burst_left = 0;
  bit       tx_gaps = 1'b1;
  rx_mode_t rx_mode = RX_CHOPPY;
  bit       rx_on = 1'b0;
  int       rx_run = 0;

  clipped_alpha_sprite_blitter_core #(
    .MAX_CANVAS_DIM  (MAX_CANVAS_DIM),
    .MAX_SPRITE_DIM  (MAX_SPRITE_DIM),
    .OPAQUE_THRESHOLD(OPAQUE_THRESHOLD)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_kind          (in_kind),
    .in_sprite_start  (in_sprite_start),
    .in_data_rgba     (in_data_rgba),
    .in_canvas_address(in_canvas_address),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_pixel_address(out_pixel_address),
    .out_pixel_rgba   (out_pixel_rgba),
    .out_pixel_written(out_pixel_written),
    .out_pixel_clipped(out_pixel_clipped)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("clipped_alpha_sprite_blitter_core verification failed");
    $finish;
  end

  function automatic int eff_dim(input logic [DIM_W-1:0] v, input int maxv);
    if (v < 1) return 1;
    if (v > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic logic [7:0] mix_channel(input logic [7:0] s, input logic [7:0] d,
                                             input logic [7:0] a);
    int t;
    t = (int'(s) * int'(a) + int'(d) * (255 - int'(a))) / 255;
    return t[7:0];
  endfunction

  // canvas word that the next sprite pixel lands on; returns 0 when off the canvas
  function automatic bit locate_pixel(input logic restart,
                                      output logic [CANVAS_ADDR_W-1:0] waddr);
    int cw, ch, dx, dy, t;
    cw = eff_dim(canvas_w_reg, MAX_CANVAS_DIM);
    ch = eff_dim(canvas_h_reg, MAX_CANVAS_DIM);
    dx = int'(origin_x_reg) + (restart ? 0 : sprite_col);
    dy = int'(origin_y_reg) + (restart ? 0 : sprite_row);
    t = dy * cw + dx;
    waddr = t[CANVAS_ADDR_W-1:0];
    return !(dx < 0 || dy < 0 || dx >= cw || dy >= ch);
  endfunction

  function automatic void store_word(input logic [CANVAS_ADDR_W-1:0] a,
                                     input logic [RGBA_W-1:0] v);
    canvas_img[a] = v;
    if (!canvas_known[a]) begin
      canvas_known[a] = 1'b1;
      known_addrs.push_back(int'(a));
    end
  endfunction

  function automatic res_t apply_request(input blit_req_t r);
    res_t                     res;
    logic [CANVAS_ADDR_W-1:0] waddr;
    logic [RGBA_W-1:0]        old_px;
    logic [RGBA_W-1:0]        new_px;
    logic [7:0]               a;
    bit                       on_canvas;
    res = '0;
    a = r.rgba[31:24];
    case (r.kind)
      KIND_PIXEL: begin
        on_canvas = locate_pixel(r.start, waddr);
        if (r.start) begin
          sprite_col = 0;
          sprite_row = 0;
        end
        // clipping wins over a zero alpha
        if (!on_canvas) begin
          res.clipped = 1'b1;
        end else if (a != 8'd0) begin
          if (a >= OPAQUE_THRESHOLD) begin
            new_px = {ALPHA_OPAQUE, r.rgba[23:0]};
          end else begin
            old_px = canvas_img[waddr];
            new_px = {ALPHA_OPAQUE, mix_channel(r.rgba[23:16], old_px[23:16], a),
                      mix_channel(r.rgba[15:8], old_px[15:8], a),
                      mix_channel(r.rgba[7:0], old_px[7:0], a)};
          end
          store_word(waddr, new_px);
          res.addr    = waddr;
          res.rgba    = new_px;
          res.written = 1'b1;
        end
        sprite_col++;
        if (sprite_col >= eff_dim(sprite_w_reg, MAX_SPRITE_DIM)) begin
          sprite_col = 0;
          sprite_row++;
          if (sprite_row >= eff_dim(sprite_h_reg, MAX_SPRITE_DIM)) sprite_row = 0;
        end
      end
      KIND_READ: begin
        res.addr = r.addr;
        res.rgba = canvas_img[r.addr];
      end
      KIND_WRITE: begin
        store_word(r.addr, r.rgba);
        res.addr    = r.addr;
        res.rgba    = r.rgba;
        res.written = 1'b1;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void apply_config(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] v);
    case (idx)
      CFG_CANVAS_WIDTH:  canvas_w_reg = v[DIM_W-1:0];
      CFG_CANVAS_HEIGHT: canvas_h_reg = v[DIM_W-1:0];
      CFG_SPRITE_WIDTH:  sprite_w_reg = v[DIM_W-1:0];
      CFG_SPRITE_HEIGHT: sprite_h_reg = v[DIM_W-1:0];
      CFG_ORIGIN_X:      origin_x_reg = v;
      CFG_ORIGIN_Y:      origin_y_reg = v;
      default: ;
    endcase
  endfunction

  task automatic send_req(input logic [KIND_W-1:0] kind, input logic start,
                          input logic [RGBA_W-1:0] rgba,
                          input logic [CANVAS_ADDR_W-1:0] addr);
    blit_req_t                r;
    logic [CANVAS_ADDR_W-1:0] dest;
    int                       gap;
    r = '{kind, start, rgba, addr};
    // never let the block read a canvas word that was never written
    if (kind == KIND_PIXEL && rgba[31:24] != 8'd0 && rgba[31:24] < OPAQUE_THRESHOLD &&
        locate_pixel(start, dest) && !canvas_known[dest]) begin
      r.rgba[31:24] = ALPHA_OPAQUE;
    end
    if (kind == KIND_READ && !canvas_known[addr]) r.kind = KIND_WRITE;
    if (tx_burst_left == 0) begin
      tx_burst_left = $urandom_range(1, 24);
      gap = tx_gaps ? $urandom_range(0, 7) : 0;
      if (gap != 0) begin
        in_push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    tx_burst_left--;
    in_push           <= 1'b1;
    in_kind           <= r.kind;
    in_sprite_start   <= r.start;
    in_data_rgba      <= r.rgba;
    in_canvas_address <= r.addr;
    do @(posedge clk); while (in_full);
    canvas_results_q.push_back(apply_request(r));
    sent_count++;
  endtask

  // wait until every request has its result back and the pipe is quiet
  task automatic settle();
    in_push <= 1'b0;
    tx_burst_left = 0;
    while (canvas_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_config(idx, v);
  endtask

  task automatic send_host_item();
    logic [RGBA_W-1:0]        v;
    logic [CANVAS_ADDR_W-1:0] a;
    int                       pick;
    pick = $urandom_range(0, 9);
    v = $urandom();
    a = 16'($urandom_range(0, 65535));
    if (pick < 4) begin
      send_req(KIND_WRITE, v[0], $urandom(), a);
    end else if (pick < 8 && known_addrs.size() != 0) begin
      send_req(KIND_READ, v[1], v,
               16'(known_addrs[$urandom_range(0, known_addrs.size() - 1)]));
    end else begin
      send_req(KIND_UNUSED, v[2], v, a);
    end
  endtask

  // reset settings: 256x256 canvas, 1x1 sprite at the origin
  task automatic test_reset_settings();
    tx_gaps = 1'b1;
    rx_mode = RX_CHOPPY;
    send_req(KIND_WRITE, 1'b1, 32'hFFFF_FFFF, 16'hFFFF);
    send_req(KIND_READ, 1'b1, 32'h0000_0000, 16'hFFFF);
    send_req(KIND_WRITE, 1'b0, 32'h0000_0000, 16'h0000);
    send_req(KIND_READ, 1'b0, 32'hFFFF_FFFF, 16'h0000);
    send_req(KIND_UNUSED, 1'b1, 32'hFFFF_FFFF, 16'hFFFF);
    send_req(KIND_PIXEL, 1'b1, 32'h00AB_CDEF, 16'h0000);
    send_req(KIND_PIXEL, 1'b0, 32'hFF12_3456, 16'h0000);
    send_req(KIND_PIXEL, 1'b0, 32'hFA80_4020, 16'h0000);
    send_req(KIND_PIXEL, 1'b0, 32'hF9FF_007F, 16'h0000);
    send_req(KIND_PIXEL, 1'b0, 32'h01FF_FFFF, 16'h0000);
    send_req(KIND_PIXEL, 1'b0, 32'h8000_FF00, 16'hFFFF);
  endtask

  task automatic test_register_limits();
    rx_mode = RX_SLOW;
    // width 0 clamps to 1, height with high bits set clamps to the maximum
    write_reg(CFG_CANVAS_WIDTH, 11'h600);
    write_reg(CFG_CANVAS_HEIGHT, 11'h7FF);
    write_reg(CFG_SPRITE_WIDTH, 11'd3);
    write_reg(CFG_SPRITE_HEIGHT, 11'd2);
    write_reg(CFG_ORIGIN_X, 11'd0);
    write_reg(CFG_ORIGIN_Y, 11'h7FF);
    send_req(KIND_PIXEL, 1'b1, 32'h0011_2233, 16'h0000);
    send_req(KIND_PIXEL, 1'b0, 32'hFF44_5566, 16'h0000);
    send_req(KIND_PIXEL, 1'b0, 32'h8077_8899, 16'h0000);
    send_req(KIND_PIXEL, 1'b0, 32'hFFAA_BBCC, 16'h0000);
    send_req(KIND_PIXEL, 1'b0, 32'hFFDD_EEFF, 16'h0000);
    send_req(KIND_PIXEL, 1'b0, 32'h0001_0203, 16'h0000);
    // raster wraps back to the clipped first row
    send_req(KIND_PIXEL, 1'b0, 32'hFF04_0506, 16'h0000);
    write_reg(CFG_ORIGIN_X, 11'h400);
    write_reg(CFG_ORIGIN_Y, 11'h3FF);
    send_req(KIND_PIXEL, 1'b1, 32'hFF07_0809, 16'h0000);
    write_reg(CFG_CANVAS_WIDTH, 11'd256);
    write_reg(CFG_SPRITE_WIDTH, 11'd0);
    write_reg(CFG_SPRITE_HEIGHT, 11'h1FF);
    write_reg(CFG_ORIGIN_X, 11'd0);
    write_reg(CFG_ORIGIN_Y, 11'd0);
    send_req(KIND_PIXEL, 1'b1, 32'hFF0A_0B0C, 16'h0000);
    send_req(KIND_PIXEL, 1'b0, 32'hFF0D_0E0F, 16'h0000);
    send_req(KIND_PIXEL, 1'b0, 32'h4010_1112, 16'h0000);
  endtask

  task automatic test_random_sprites(input int item_goal);
    logic [CFG_DATA_W-1:0] v;
    logic [RGBA_W-1:0]     colour;
    logic [7:0]            alpha;
    logic                  start;
    bit                    fresh_canvas;
    int                    sw, sh, cw, pick, npix, passes, t, i;
    fresh_canvas = 1'b1;
    while (sent_count < item_goal) begin
      if (fresh_canvas || $urandom_range(0, 9) < 3) begin
        for (i = 0; i < 2; i++) begin
          pick = $urandom_range(0, 19);
          if (pick < 14) v = 11'($urandom_range(1, 24));
          else if (pick < 17) v = 11'($urandom_range(25, 256));
          else if (pick < 19) v = {2'($urandom_range(0, 3)), 9'd0};
          else v = 11'($urandom_range(257, 2047));
          write_reg(i == 0 ? CFG_CANVAS_WIDTH : CFG_CANVAS_HEIGHT, v);
        end
        fresh_canvas = 1'b0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        write_reg(CFG_SPRITE_WIDTH, 11'($urandom_range(256, 511)));
        write_reg(CFG_SPRITE_HEIGHT, 11'($urandom_range(0, 1)));
      end else begin
        write_reg(CFG_SPRITE_WIDTH, pick < 10 ? 11'd0 : 11'($urandom_range(1, 10)));
        write_reg(CFG_SPRITE_HEIGHT, pick > 92 ? 11'd0 : 11'($urandom_range(1, 8)));
      end
      sw = eff_dim(sprite_w_reg, MAX_SPRITE_DIM);
      sh = eff_dim(sprite_h_reg, MAX_SPRITE_DIM);
      cw = eff_dim(canvas_w_reg, MAX_CANVAS_DIM);
      t = $urandom_range(0, cw + sw + 1) - sw - 1;
      write_reg(CFG_ORIGIN_X, $urandom_range(0, 4) == 0 ? 11'($urandom()) : t[10:0]);
      t = $urandom_range(0, eff_dim(canvas_h_reg, MAX_CANVAS_DIM) + sh + 1) - sh - 1;
      write_reg(CFG_ORIGIN_Y, $urandom_range(0, 4) == 0 ? 11'($urandom()) : t[10:0]);
      tx_gaps = $urandom_range(0, 3) != 0;
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      npix = sw * sh;
      passes = $urandom_range(0, 9) < 4 ? 2 : 1;
      repeat (passes) begin
        for (i = 0; i < npix; i++) begin
          if ($urandom_range(0, 19) == 0) send_host_item();
          // an occasional restart in the middle breaks the raster sequence
          start = (i == 0) || ($urandom_range(0, 49) == 0);
          pick = $urandom_range(0, 19);
          if (pick < 4) alpha = 8'd0;
          else if (pick < 9) alpha = 8'($urandom_range(OPAQUE_THRESHOLD, 255));
          else if (pick < 11) alpha = pick[0] ? 8'd1 : 8'(OPAQUE_THRESHOLD - 1);
          else alpha = 8'($urandom_range(1, OPAQUE_THRESHOLD - 1));
          colour = $urandom();
          send_req(KIND_PIXEL, start, {alpha, colour[23:0]}, colour[31:16]);
        end
      end
    end
  endtask

  task automatic test_host_access(input int count);
    tx_gaps = 1'b0;
    rx_mode = RX_STEADY;
    repeat (count / 2) send_host_item();
    tx_gaps = 1'b1;
    rx_mode = RX_SLOW;
    repeat (count - count / 2) send_host_item();
  endtask

  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (canvas_results_q.size() == 0) begin
        $error("result popped with no request outstanding: addr %h rgba %h",
               out_pixel_address, out_pixel_rgba);
        mismatches++;
      end else begin
        want = canvas_results_q.pop_front();
        if (out_pixel_address !== want.addr) begin
          $error("pixel_address expected %h got %h", want.addr, out_pixel_address);
          mismatches++;
        end
        if (out_pixel_rgba !== want.rgba) begin
          $error("pixel_rgba expected %h got %h", want.rgba, out_pixel_rgba);
          mismatches++;
        end
        if (out_pixel_written !== want.written) begin
          $error("pixel_written expected %b got %b", want.written, out_pixel_written);
          mismatches++;
        end
        if (out_pixel_clipped !== want.clipped) begin
          $error("pixel_clipped expected %b got %b", want.clipped, out_pixel_clipped);
          mismatches++;
        end
      end
    end
    // receiver alternates pop runs and stall runs, but always pops in steady mode
    if (rx_run == 0) begin
      rx_on = (rx_mode == RX_STEADY) ? 1'b1 : !rx_on;
      rx_run = rx_on ? $urandom_range(1, 12) : $urandom_range(1, rx_mode == RX_SLOW ? 24 : 3);
    end
    rx_run--;
    out_pop <= rst_n && rx_on;
  end

  initial begin
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= CFG_CANVAS_WIDTH;
    cfg_data          <= '0;
    in_push           <= 1'b0;
    in_kind           <= KIND_PIXEL;
    in_sprite_start   <= 1'b0;
    in_data_rgba      <= '0;
    in_canvas_address <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_settings();
    test_register_limits();
    test_random_sprites(820);
    test_host_access(150);
    settle();
    if (mismatches == 0 && canvas_results_q.size() == 0) begin
      $display("clipped_alpha_sprite_blitter_core verification clean");
    end else begin
      $display("clipped_alpha_sprite_blitter_core verification failed");
    end
    $finish;
  end

endmodule
